FILE: design/cpsd_pkg.sv
// cpsd_pkg: shared types and constants for the control pilot state debounce block
// no dependencies; imported by every module of the block

package cpsd_pkg;

    localparam int LEVEL_COUNT = 6;
    localparam int LEVEL_W     = 12;
    localparam int TOL_W       = 11;
    localparam int CLASS_W     = 3;
    localparam int GUN_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    typedef logic [CLASS_W-1:0] class_t;

    localparam class_t CLASS_A       = 3'd0;
    localparam class_t CLASS_B       = 3'd1;
    localparam class_t CLASS_C       = 3'd2;
    localparam class_t CLASS_D       = 3'd3;
    localparam class_t CLASS_E       = 3'd4;
    localparam class_t CLASS_F       = 3'd5;
    localparam class_t CLASS_UNKNOWN = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_E   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_F   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd6;

    localparam logic signed [LEVEL_W-1:0] LEVEL_A_RST = 12'sd1200;
    localparam logic signed [LEVEL_W-1:0] LEVEL_B_RST = 12'sd900;
    localparam logic signed [LEVEL_W-1:0] LEVEL_C_RST = 12'sd600;
    localparam logic signed [LEVEL_W-1:0] LEVEL_D_RST = 12'sd300;
    localparam logic signed [LEVEL_W-1:0] LEVEL_E_RST = 12'sd0;
    localparam logic signed [LEVEL_W-1:0] LEVEL_F_RST = -12'sd1200;
    localparam logic [TOL_W-1:0]          TOL_RST     = 11'd100;

    typedef logic [LEVEL_COUNT-1:0][LEVEL_W-1:0] level_set_t;

    typedef struct packed {
        logic [GUN_W-1:0]          gun;
        logic signed [LEVEL_W-1:0] pilot_voltage;
    } in_beat_t;

    typedef struct packed {
        logic [GUN_W-1:0] gun_out;
        class_t           sample_class;
        class_t           confirmed_state;
        logic             changed;
    } out_beat_t;

    typedef struct packed {
        class_t state;
        logic   changed;
    } dbn_result_t;

endpackage

FILE: design/cpsd_classify.sv
// cpsd_classify: six parallel window comparisons of a pilot sample against the state levels
// depends on cpsd_pkg

module cpsd_classify
    import cpsd_pkg::*;
(
    input  logic signed [LEVEL_W-1:0] pilot_voltage,
    input  level_set_t                levels,
    input  logic [TOL_W-1:0]          tolerance,
    output class_t                    sample_class
);

    logic [LEVEL_COUNT-1:0] hit;

    always_comb
    begin
        logic signed [LEVEL_W:0] diff;
        logic [LEVEL_W:0]        mag;
        for (int k = 0; k < LEVEL_COUNT; k++)
        begin
            diff = (LEVEL_W+1)'(pilot_voltage) - (LEVEL_W+1)'(signed'(levels[k]));
            mag  = diff[LEVEL_W] ? (LEVEL_W+1)'(-diff) : (LEVEL_W+1)'(diff);
            hit[k] = (mag <= (LEVEL_W+1)'(tolerance));
        end
    end

    // earliest state in a..f order wins
    always_comb
    begin
        sample_class = CLASS_UNKNOWN;
        for (int k = LEVEL_COUNT-1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                sample_class = CLASS_W'(k);
            end
        end
    end

endmodule

FILE: design/cpsd_debounce.sv
// cpsd_debounce: per-gun confirmed state, candidate and repeat counter
// depends on cpsd_pkg

module cpsd_debounce
    import cpsd_pkg::*;
#(
    parameter int NUM_GUNS      = 4,
    parameter int CONFIRM_COUNT = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             upd,
    input  logic [GUN_W-1:0] gun,
    input  class_t           cls,
    output dbn_result_t      res
);

    localparam int GUN_LIMIT = 1 << GUN_W;
    localparam int GUN_DEPTH = (NUM_GUNS < GUN_LIMIT) ? NUM_GUNS : GUN_LIMIT;
    localparam int GIDX_W    = (GUN_DEPTH > 1) ? $clog2(GUN_DEPTH) : 1;
    localparam int CNT_W     = (CONFIRM_COUNT > 1) ? $clog2(CONFIRM_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CONFIRM_COUNT - 1);

    class_t           confirmed_reg [GUN_DEPTH];
    class_t           confirmed_next[GUN_DEPTH];
    class_t           candidate_reg [GUN_DEPTH];
    class_t           candidate_next[GUN_DEPTH];
    logic [CNT_W-1:0] count_reg     [GUN_DEPTH];
    logic [CNT_W-1:0] count_next    [GUN_DEPTH];

    logic              in_range;
    logic [GIDX_W-1:0] idx;
    logic              same_conf;
    logic              same_cand;
    logic              confirm;

    assign in_range  = (32'(gun) < NUM_GUNS);
    assign idx       = gun[GIDX_W-1:0];
    assign same_conf = in_range && (confirmed_reg[idx] == cls);
    assign same_cand = in_range && (candidate_reg[idx] == cls);
    assign confirm   = in_range && !same_conf && same_cand && (count_reg[idx] == CNT_LAST);

    always_comb
    begin
        res.state   = CLASS_UNKNOWN;
        res.changed = 1'b0;
        if (in_range)
        begin
            res.state   = confirm ? cls : confirmed_reg[idx];
            res.changed = confirm;
        end
    end

    always_comb
    begin
        for (int g = 0; g < GUN_DEPTH; g++)
        begin
            confirmed_next[g] = confirmed_reg[g];
            candidate_next[g] = candidate_reg[g];
            count_next[g]     = count_reg[g];
            if (upd && in_range && (GIDX_W'(g) == idx) && !same_conf)
            begin
                if (same_cand)
                begin
                    if (confirm)
                    begin
                        confirmed_next[g] = candidate_reg[g];
                        count_next[g]     = '0;
                    end
                    else
                    begin
                        count_next[g] = count_reg[g] + CNT_W'(1);
                    end
                end
                else
                begin
                    candidate_next[g] = cls;
                    count_next[g]     = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GUN_DEPTH; g++)
            begin
                confirmed_reg[g] <= CLASS_UNKNOWN;
                candidate_reg[g] <= CLASS_UNKNOWN;
                count_reg[g]     <= '0;
            end
        end
        else
        begin
            for (int g = 0; g < GUN_DEPTH; g++)
            begin
                confirmed_reg[g] <= confirmed_next[g];
                candidate_reg[g] <= candidate_next[g];
                count_reg[g]     <= count_next[g];
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_range |-> (32'(count_reg[idx]) < CONFIRM_COUNT))
        else $error("repeat counter reached confirm count");

    a_change_src: assert property (@(posedge clk) disable iff (!rst_n)
        res.changed |-> (candidate_reg[idx] == cls) && (confirmed_reg[idx] != cls))
        else $error("state change without a matching candidate");

    a_change_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && res.changed) |=> (confirmed_reg[$past(idx)] == $past(cls)))
        else $error("confirmed state not updated after change");

endmodule

FILE: design/control_pilot_state_debounce_top.sv
// control_pilot_state_debounce_top: input register, config registers, result register
// depends on cpsd_pkg, cpsd_classify, cpsd_debounce

// One result beat per input beat, one beat per cycle sustained while out_ready is held
// high. A sample sits in the input register, is classified and applied to its gun's
// debounce state in the same cycle, and lands in the result register, from which the
// result beat is taken. The per-gun update path (state read, compare, write back)
// sets the rate; back-to-back samples for the same gun see each other's updates with
// no stall. Level and tolerance registers are written through the cfg port; the user
// must write them only while idle, as the block itself does not enforce it.

module control_pilot_state_debounce_top
    import cpsd_pkg::*;
#(
    parameter int NUM_GUNS      = 4,
    parameter int CONFIRM_COUNT = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    level_set_t       level_reg;
    level_set_t       level_next;
    logic [TOL_W-1:0] tol_reg;
    logic [TOL_W-1:0] tol_next;

    in_beat_t  item_reg;
    logic      item_valid_reg;
    logic      item_valid_next;
    out_beat_t out_reg;
    out_beat_t out_next;
    logic      out_valid_reg;
    logic      out_valid_next;

    logic        advance;
    logic        in_fire;
    class_t      cls;
    dbn_result_t dbn;

    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // config writes
    always_comb
    begin
        level_next = level_reg;
        tol_next   = tol_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_LEVEL_A:   level_next[0] = cfg_data;
                REG_LEVEL_B:   level_next[1] = cfg_data;
                REG_LEVEL_C:   level_next[2] = cfg_data;
                REG_LEVEL_D:   level_next[3] = cfg_data;
                REG_LEVEL_E:   level_next[4] = cfg_data;
                REG_LEVEL_F:   level_next[5] = cfg_data;
                REG_TOLERANCE: tol_next      = cfg_data[TOL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg[0] <= LEVEL_A_RST;
            level_reg[1] <= LEVEL_B_RST;
            level_reg[2] <= LEVEL_C_RST;
            level_reg[3] <= LEVEL_D_RST;
            level_reg[4] <= LEVEL_E_RST;
            level_reg[5] <= LEVEL_F_RST;
            tol_reg      <= TOL_RST;
        end
        else
        begin
            level_reg <= level_next;
            tol_reg   <= tol_next;
        end
    end

    cpsd_classify u_classify (
        .pilot_voltage (item_reg.pilot_voltage),
        .levels        (level_reg),
        .tolerance     (tol_reg),
        .sample_class  (cls)
    );

    cpsd_debounce #(
        .NUM_GUNS      (NUM_GUNS),
        .CONFIRM_COUNT (CONFIRM_COUNT)
    ) u_debounce (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (advance),
        .gun   (item_reg.gun),
        .cls   (cls),
        .res   (dbn)
    );

    always_comb
    begin
        item_valid_next = in_fire || (item_valid_reg && !advance);
        out_valid_next  = advance || (out_valid_reg && !out_ready);
        out_next        = out_reg;
        if (advance)
        begin
            out_next.gun_out         = item_reg.gun;
            out_next.sample_class    = cls;
            out_next.confirmed_state = dbn.state;
            out_next.changed         = dbn.changed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        out_reg <= out_next;
    end

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> (item_valid_reg && $stable(item_reg)))
        else $error("pending input beat lost");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result beat missing after advance");

    a_change_class: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.changed) |-> (out_reg.sample_class == out_reg.confirmed_state))
        else $error("changed beat with mismatched state");

endmodule

FILE: test/pilot_check_pkg.sv
// pilot_check_pkg: expected-result tracker for the control pilot state debounce testbench
// depends on cpsd_pkg; imported by tb_top

package pilot_check_pkg;

    import cpsd_pkg::*;

    localparam int GUNS    = 4;
    localparam int CONFIRM = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    class pilot_state_tracker;
        logic signed [LEVEL_W-1:0] level [LEVEL_COUNT];
        logic [TOL_W-1:0]          tolerance;
        class_t                    confirmed [GUNS];
        class_t                    candidate [GUNS];
        int unsigned               repeats [GUNS];
        out_beat_t                 expected_q [$];
        int                        mismatches;

        function new();
            level[0]   = LEVEL_A_RST;
            level[1]   = LEVEL_B_RST;
            level[2]   = LEVEL_C_RST;
            level[3]   = LEVEL_D_RST;
            level[4]   = LEVEL_E_RST;
            level[5]   = LEVEL_F_RST;
            tolerance  = TOL_RST;
            mismatches = 0;
            for (int g = 0; g < GUNS; g++)
            begin
                confirmed[g] = CLASS_UNKNOWN;
                candidate[g] = CLASS_UNKNOWN;
                repeats[g]   = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_TOLERANCE)
                tolerance = data[TOL_W-1:0];
            else if (idx <= REG_LEVEL_F)
                level[idx - REG_LEVEL_A] = data;
        endfunction

        // first window in A..F order wins
        function class_t classify(logic signed [LEVEL_W-1:0] v);
            int gap;
            for (int k = 0; k < LEVEL_COUNT; k++)
            begin
                gap = int'(v) - int'(level[k]);
                if (gap < 0)
                    gap = -gap;
                if (gap <= int'(tolerance))
                    return class_t'(k);
            end
            return CLASS_UNKNOWN;
        endfunction

        function void note_sample(in_beat_t b);
            out_beat_t r;
            class_t    c;
            int        g;
            c                 = classify(b.pilot_voltage);
            g                 = b.gun;
            r.gun_out         = b.gun;
            r.sample_class    = c;
            r.confirmed_state = CLASS_UNKNOWN;
            r.changed         = 1'b0;
            if (g < GUNS)
            begin
                if (confirmed[g] != c)
                begin
                    if (candidate[g] == c)
                    begin
                        if (repeats[g] + 1 >= CONFIRM)
                        begin
                            confirmed[g] = c;
                            repeats[g]   = 0;
                            r.changed    = 1'b1;
                        end
                        else
                            repeats[g]++;
                    end
                    else
                    begin
                        candidate[g] = c;
                        repeats[g]   = 0;
                    end
                end
                r.confirmed_state = confirmed[g];
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: gun %0d class %0d state %0d changed %0d",
                             got.gun_out, got.sample_class, got.confirmed_state, got.changed);
                return;
            end
            want = expected_q.pop_front();
            if (got.gun_out !== want.gun_out || got.sample_class !== want.sample_class ||
                got.confirmed_state !== want.confirmed_state || got.changed !== want.changed)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp gun %0d class %0d state %0d changed %0d,",
                              " got gun %0d class %0d state %0d changed %0d"},
                             want.gun_out, want.sample_class, want.confirmed_state,
                             want.changed, got.gun_out, got.sample_class,
                             got.confirmed_state, got.changed);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

FILE: test/tb_top.sv
// tb_top: drives pilot samples and level settings into control_pilot_state_debounce_top
// depends on cpsd_pkg, pilot_check_pkg and the block's RTL

module tb_top;

    import cpsd_pkg::*;
    import pilot_check_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 64;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_beat_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_beat_t             out_data;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pilot_state_tracker tracker = new();

    bit tx_gaps;
    bit rx_gaps;
    int rx_hold_req;
    int tx_calm;
    int items_sent;
    int hold_at;
    int pause_at;

    control_pilot_state_debounce_top #(
        .NUM_GUNS      (GUNS),
        .CONFIRM_COUNT (CONFIRM)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: check accepted beats, stall in bursts or on a long hold request
    initial
    begin
        int hold;
        int calm;
        hold = 0;
        calm = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_result(out_data);
            if (calm > 0)
                calm--;
            else if ($urandom_range(0, 63) == 0)
                calm = $urandom_range(20, 80);
            if (rx_hold_req > 0)
            begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
            end
            else if (hold == 0 && rx_gaps && calm == 0 && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 6);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic put_beat(input int g, input int v);
        in_beat_t b;
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        b.gun           = g[GUN_W-1:0];
        b.pilot_voltage = v[LEVEL_W-1:0];
        if (items_sent == pause_at)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (tracker.pending() != 0);
        end
        if (items_sent == hold_at)
            rx_hold_req = LONG_HOLD;
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_sample(b);
        items_sent++;
        if (tx_calm > 0)
            tx_calm--;
        else if ($urandom_range(0, 31) == 0)
            tx_calm = $urandom_range(15, 60);
        if (tx_gaps && tx_calm == 0 && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic int any_voltage();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    // sample inside or on the edge of the window of class k, any voltage for k past class F
    function automatic int near_level(int k);
        int lvl;
        int tol;
        if (k >= LEVEL_COUNT)
            return any_voltage();
        lvl = tracker.level[k];
        tol = tracker.tolerance;
        case ($urandom_range(0, 3))
            0:       return lvl - tol;
            1:       return lvl + tol;
            default: return lvl - tol + int'($urandom_range(0, 2 * tol));
        endcase
    endfunction

    // mostly runs of one class on one gun, mixed with noise on random guns
    task automatic run_random(input int n);
        int last;
        int g;
        int k;
        int len;
        last = items_sent + n;
        while (items_sent < last)
        begin
            if ($urandom_range(0, 9) < 2)
                put_beat($urandom_range(0, GUNS - 1), any_voltage());
            else
            begin
                g   = $urandom_range(0, GUNS - 1);
                k   = $urandom_range(0, LEVEL_COUNT);
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        put_beat($urandom_range(0, GUNS - 1), any_voltage());
                    put_beat(g, near_level(k));
                end
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        tracker.write_reg(idx, val[CFG_DATA_W-1:0]);
    endtask

    task automatic load_setting(input int a, input int b, input int c, input int d,
                                input int e, input int f, input int tol);
        write_reg(REG_LEVEL_A, a);
        write_reg(REG_LEVEL_B, b);
        write_reg(REG_LEVEL_C, c);
        write_reg(REG_LEVEL_D, d);
        write_reg(REG_LEVEL_E, e);
        write_reg(REG_LEVEL_F, f);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_SPARE, $urandom);
        cfg_wen <= 1'b0;
    endtask

    function automatic int random_level();
        if ($urandom_range(0, 7) == 0)
            return any_voltage();
        return int'($urandom_range(0, 3000)) - 1500;
    endfunction

    task automatic random_setting();
        int tol;
        if ($urandom_range(0, 3) == 0)
            tol = $urandom_range(0, 1500);
        else
            tol = $urandom_range(0, 150);
        // bit 11 lies above the tolerance register
        tol = tol | ($urandom_range(0, 1) << TOL_W);
        load_setting(random_level(), random_level(), random_level(), random_level(),
                     random_level(), random_level(), tol);
    endtask

    initial
    begin
        int side_vals [10];
        side_vals = '{900, 600, 300, 0, -1200, 1301, 1500, -1500, 2047, -2048};
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        cfg_wen    <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        tx_gaps     = 1'b0;
        rx_gaps     = 1'b0;
        rx_hold_req = 0;
        tx_calm     = 0;
        items_sent  = 0;
        hold_at     = -1;
        pause_at    = -1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // state A confirmed on the fourth sample, window edges included
        put_beat(0, 1200);
        put_beat(0, 1100);
        put_beat(0, 1300);
        put_beat(0, 1250);
        put_beat(0, 1200);
        // classes B to F, outside a window, field extremes
        foreach (side_vals[i])
            put_beat(1, side_vals[i]);
        // candidate interrupted before confirm
        put_beat(2, 600);
        put_beat(2, 600);
        put_beat(2, 300);
        put_beat(2, 600);
        put_beat(3, -1200);
        put_beat(3, -1100);
        put_beat(3, -1300);
        put_beat(3, -1250);

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        run_random(180);
        drain();

        // register extremes, exact match only
        load_setting(2047, -2048, -1500, 1500, 0, -1, 0);
        run_random(200);
        drain();

        // overlapping windows, widest tolerance
        load_setting(100, 100, -100, 50, 0, -50, 12'hFFF);
        run_random(120);
        drain();

        hold_at = items_sent + 100;
        random_setting();
        run_random(300);
        drain();

        pause_at = items_sent + 150;
        random_setting();
        run_random(300);
        drain();

        random_setting();
        run_random(300);
        drain();

        random_setting();
        run_random(300);
        drain();

        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        random_setting();
        run_random(300);
        drain();

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
design/cpsd_pkg.sv
design/cpsd_classify.sv
design/cpsd_debounce.sv
design/control_pilot_state_debounce_top.sv
test/pilot_check_pkg.sv
test/tb_top.sv
